### hw/rtl/sacache_pkg.sv
// shared constants and types for the set-associative cache hit/miss tracker
package sacache_pkg;

	// default geometry
	localparam int DEF_WAYS       = 4;
	localparam int DEF_MAX_SETS   = 128;
	localparam int DEF_ADDR_WIDTH = 32;

	// fixed field widths
	localparam int CNT_W     = 32;
	localparam int WAY_OUT_W = 2;
	localparam int CFG_W     = 3;
	localparam int CFG_IDX_W = 2;
	localparam int SHIFT_W   = 3;
	localparam int SET_SEL_W = 7;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_REPLACE_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_OFFSET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SET_INDEX    = 2'd2;

	// replacement policies
	localparam logic MODE_LRU  = 1'b0;
	localparam logic MODE_FIFO = 1'b1;

	// register reset values
	localparam logic               RST_REPLACE_MODE = MODE_LRU;
	localparam logic [SHIFT_W-1:0] RST_BLOCK_OFFSET = 3'd4;
	localparam logic [SHIFT_W-1:0] RST_SET_INDEX    = 3'd4;

	// lookup status handed from the way selector to the top level
	typedef struct packed {
		logic hit;
		logic wr_en;
	} sel_status_t;

endpackage

### hw/rtl/sacache_way_sel.sv
// tag compare, victim choice and age update for one set row
module sacache_way_sel #(
	parameter int WAYS       = sacache_pkg::DEF_WAYS,
	parameter int ADDR_WIDTH = sacache_pkg::DEF_ADDR_WIDTH,
	parameter int AGE_W      = $clog2(WAYS),
	parameter int WAY_IDX_W  = $clog2(WAYS)
) (
	input  logic                       replace_mode,
	input  logic [ADDR_WIDTH-1:0]      blk,
	input  logic [WAYS-1:0]            valid_in,
	input  logic [WAYS*AGE_W-1:0]      ages_in,
	input  logic [WAYS*ADDR_WIDTH-1:0] tags_in,
	output sacache_pkg::sel_status_t   status,
	output logic [WAY_IDX_W-1:0]       way_idx,
	output logic [WAYS-1:0]            valid_out,
	output logic [WAYS*AGE_W-1:0]      ages_out,
	output logic [WAYS*ADDR_WIDTH-1:0] tags_out
);

	logic [WAYS-1:0] match;

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			match[w] = valid_in[w] && (tags_in[w*ADDR_WIDTH +: ADDR_WIDTH] == blk);
		end
	end

	// pick the way: lowest match, else lowest invalid, else oldest
	always_comb begin
		logic [WAY_IDX_W-1:0] hit_w;
		logic [WAY_IDX_W-1:0] free_w;
		logic [WAY_IDX_W-1:0] old_w;
		logic [AGE_W-1:0]     best;
		hit_w  = '0;
		free_w = '0;
		old_w  = '0;
		best   = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit_w = WAY_IDX_W'(w);
			end
			if (!valid_in[w]) begin
				free_w = WAY_IDX_W'(w);
			end
		end
		for (int w = 0; w < WAYS; w++) begin
			if (w == 0 || ages_in[w*AGE_W +: AGE_W] > best) begin
				best  = ages_in[w*AGE_W +: AGE_W];
				old_w = WAY_IDX_W'(w);
			end
		end
		status.hit   = |match;
		status.wr_en = (|match) ? (replace_mode == sacache_pkg::MODE_LRU) : 1'b1;
		if (|match) begin
			way_idx = hit_w;
		end else if (!(&valid_in)) begin
			way_idx = free_w;
		end else begin
			way_idx = old_w;
		end
	end

	// chosen way becomes youngest; valid ways younger than its old rank age by one
	always_comb begin
		logic [AGE_W:0] old_rank;
		old_rank = valid_in[way_idx] ? {1'b0, ages_in[way_idx*AGE_W +: AGE_W]}
			: (AGE_W+1)'(WAYS);
		valid_out = valid_in;
		valid_out[way_idx] = 1'b1;
		tags_out = tags_in;
		if (!status.hit) begin
			tags_out[way_idx*ADDR_WIDTH +: ADDR_WIDTH] = blk;
		end
		for (int i = 0; i < WAYS; i++) begin
			if (WAY_IDX_W'(i) == way_idx) begin
				ages_out[i*AGE_W +: AGE_W] = '0;
			end else if (valid_in[i] && ({1'b0, ages_in[i*AGE_W +: AGE_W]} < old_rank)) begin
				ages_out[i*AGE_W +: AGE_W] = ages_in[i*AGE_W +: AGE_W] + 1'b1;
			end else begin
				ages_out[i*AGE_W +: AGE_W] = ages_in[i*AGE_W +: AGE_W];
			end
		end
	end

endmodule

### hw/rtl/set_assoc_cache_lru_fifo_tracker_unit.sv
// Hit/miss tracker for a set-associative cache with LRU or FIFO replacement.
// Address channel: address with address_valid / address_stall; one word address
// per transfer. Result channel: hit, way, miss_count, access_count with
// result_valid / result_stall; exactly one result per address, in order.
// Configuration: cfg_we / cfg_index / cfg_data write replace_mode (0),
// block_offset_bits (1) and set_index_bits (2); write only while idle.
// Each set is one row of a single-port-write, registered-read memory holding
// the tags, valid bits and age ranks of all ways. An address reads its row in
// the transfer cycle; the next cycle compares all ways in parallel, picks the
// way and, once the result register is free, writes the updated row back (not
// on a FIFO hit) and loads the result register. Rows are read-modify-written;
// the next address is taken once the write back is done, so a following
// access to the same set always sees the update. Reset: counters and control
// registers clear, the configuration takes its reset values, then a pass over
// all MAX_SETS rows clears the valid bits and ages row by row; address_stall
// is high during that pass. When result_stall holds the result, one more
// address is still taken and waits after its row read until the result
// register frees.
module set_assoc_cache_lru_fifo_tracker_unit #(
	parameter int WAYS       = sacache_pkg::DEF_WAYS,
	parameter int MAX_SETS   = sacache_pkg::DEF_MAX_SETS,
	parameter int ADDR_WIDTH = sacache_pkg::DEF_ADDR_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sacache_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sacache_pkg::CFG_W-1:0]       cfg_data,
	input  logic                                address_valid,
	output logic                                address_stall,
	input  logic [ADDR_WIDTH-1:0]               address,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic                                hit,
	output logic [sacache_pkg::WAY_OUT_W-1:0]   way,
	output logic [sacache_pkg::CNT_W-1:0]       miss_count,
	output logic [sacache_pkg::CNT_W-1:0]       access_count
);

	localparam int AGE_W     = $clog2(WAYS);
	localparam int WAY_IDX_W = $clog2(WAYS);
	localparam int SETW      = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int SEL_N     = 1 << sacache_pkg::SET_SEL_W;
	localparam int VAL_LO    = 0;
	localparam int AGE_LO    = WAYS;
	localparam int TAG_LO    = WAYS + WAYS * AGE_W;
	localparam int ROW_W     = TAG_LO + WAYS * ADDR_WIDTH;

	// configuration
	logic                             replace_mode_q;
	logic [sacache_pkg::SHIFT_W-1:0]  block_offset_q;
	logic [sacache_pkg::SHIFT_W-1:0]  set_index_q;

	// control
	logic            clear_q;
	logic [SETW-1:0] clr_idx_q;
	logic            busy_s1;
	logic            result_valid_q;
	logic [sacache_pkg::CNT_W-1:0] miss_q;
	logic [sacache_pkg::CNT_W-1:0] acc_q;

	// payload
	logic [ADDR_WIDTH-1:0]           blk_s1;
	logic [SETW-1:0]                 set_s1;
	logic                            hit_q;
	logic [sacache_pkg::WAY_OUT_W-1:0] way_q;

	// row memory
	logic [ROW_W-1:0] row_mem [MAX_SETS];
	logic [ROW_W-1:0] rd_q;
	logic             rd_en;
	logic [SETW-1:0]  rd_idx;
	logic             mem_we;
	logic [SETW-1:0]  mem_wa;
	logic [ROW_W-1:0] mem_wd;

	logic                             accept;
	logic                             fire;
	logic [ADDR_WIDTH-1:0]            blk_in;
	logic [sacache_pkg::SET_SEL_W-1:0] set_sel;
	logic [SETW-1:0]                  wrap_lut [SEL_N];

	sacache_pkg::sel_status_t         status;
	logic [WAY_IDX_W-1:0]             sel_way;
	logic [WAYS-1:0]                  new_valid;
	logic [WAYS*AGE_W-1:0]            new_ages;
	logic [WAYS*ADDR_WIDTH-1:0]       new_tags;

	// set number modulo MAX_SETS as a constant table
	for (genvar g = 0; g < SEL_N; g++) begin : g_wrap
		assign wrap_lut[g] = SETW'(g % MAX_SETS);
	end

	assign address_stall = clear_q | busy_s1;
	assign accept        = address_valid & ~address_stall;
	assign fire          = busy_s1 & (~result_valid_q | ~result_stall);

	assign blk_in  = address >> block_offset_q;
	assign set_sel = blk_in[sacache_pkg::SET_SEL_W-1:0]
		& ((sacache_pkg::SET_SEL_W)'(1) << set_index_q) - 1'b1;
	assign rd_en   = accept;
	assign rd_idx  = wrap_lut[set_sel];

	sacache_way_sel #(
		.WAYS       (WAYS),
		.ADDR_WIDTH (ADDR_WIDTH),
		.AGE_W      (AGE_W),
		.WAY_IDX_W  (WAY_IDX_W)
	) u_way_sel (
		.replace_mode (replace_mode_q),
		.blk          (blk_s1),
		.valid_in     (rd_q[VAL_LO +: WAYS]),
		.ages_in      (rd_q[AGE_LO +: WAYS*AGE_W]),
		.tags_in      (rd_q[TAG_LO +: WAYS*ADDR_WIDTH]),
		.status       (status),
		.way_idx      (sel_way),
		.valid_out    (new_valid),
		.ages_out     (new_ages),
		.tags_out     (new_tags)
	);

	assign mem_we = clear_q | (fire & status.wr_en);
	assign mem_wa = clear_q ? clr_idx_q : set_s1;
	assign mem_wd = clear_q ? '0 : {new_tags, new_ages, new_valid};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			row_mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_q <= row_mem[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			blk_s1 <= blk_in;
			set_s1 <= rd_idx;
		end
		if (fire) begin
			hit_q <= status.hit;
			way_q <= sacache_pkg::WAY_OUT_W'(sel_way);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replace_mode_q <= sacache_pkg::RST_REPLACE_MODE;
			block_offset_q <= sacache_pkg::RST_BLOCK_OFFSET;
			set_index_q    <= sacache_pkg::RST_SET_INDEX;
			clear_q        <= 1'b1;
			clr_idx_q      <= '0;
			busy_s1        <= 1'b0;
			result_valid_q <= 1'b0;
			miss_q         <= '0;
			acc_q          <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					sacache_pkg::REG_REPLACE_MODE: replace_mode_q <= cfg_data[0];
					sacache_pkg::REG_BLOCK_OFFSET: block_offset_q <= cfg_data;
					sacache_pkg::REG_SET_INDEX:    set_index_q    <= cfg_data;
					default: ;
				endcase
			end
			if (clear_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == SETW'(MAX_SETS - 1)) begin
					clear_q <= 1'b0;
				end
			end
			if (accept) begin
				busy_s1 <= 1'b1;
			end else if (fire) begin
				busy_s1 <= 1'b0;
			end
			if (fire) begin
				result_valid_q <= 1'b1;
				acc_q <= (&acc_q) ? acc_q : acc_q + 1'b1;
				if (!status.hit) begin
					miss_q <= (&miss_q) ? miss_q : miss_q + 1'b1;
				end
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign hit          = hit_q;
	assign way          = way_q;
	assign miss_count   = miss_q;
	assign access_count = acc_q;

endmodule

### tb/sv/tb_set_assoc_cache_lru_fifo_tracker_unit.sv
// self-checking testbench for the set-associative cache hit/miss tracker
module tb_set_assoc_cache_lru_fifo_tracker_unit;

	localparam int NWAYS = sacache_pkg::DEF_WAYS;
	localparam int NSETS = sacache_pkg::DEF_MAX_SETS;
	localparam int AW = sacache_pkg::DEF_ADDR_WIDTH;
	localparam logic [sacache_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

	typedef struct packed {
		logic hit;
		logic [sacache_pkg::WAY_OUT_W-1:0] way;
		logic [sacache_pkg::CNT_W-1:0] miss_total;
		logic [sacache_pkg::CNT_W-1:0] access_total;
	} lookup_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [sacache_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [sacache_pkg::CFG_W-1:0] cfg_data = '0;
	logic address_valid = 1'b0;
	logic address_stall;
	logic [AW-1:0] address = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic hit;
	logic [sacache_pkg::WAY_OUT_W-1:0] way;
	logic [sacache_pkg::CNT_W-1:0] miss_count;
	logic [sacache_pkg::CNT_W-1:0] access_count;

	// predictor state
	bit [AW-1:0] line_tag [NSETS*NWAYS];
	bit line_valid [NSETS*NWAYS];
	int line_age [NSETS*NWAYS];
	logic [sacache_pkg::CNT_W-1:0] misses_seen = '0;
	logic [sacache_pkg::CNT_W-1:0] accesses_seen = '0;
	logic cur_mode = sacache_pkg::RST_REPLACE_MODE;
	logic [sacache_pkg::SHIFT_W-1:0] cur_offset_bits = sacache_pkg::RST_BLOCK_OFFSET;
	logic [sacache_pkg::SHIFT_W-1:0] cur_set_bits = sacache_pkg::RST_SET_INDEX;

	logic [AW-1:0] pending_addrs [$];
	logic [AW-1:0] recent_addrs [$];
	lookup_t expected_lookups [$];
	lookup_t oldest_lookup;
	int mismatch_count = 0;
	int tx_gap = 0;
	int rx_hold = 0;
	bit tx_idle_en = 1'b0;
	bit rx_idle_en = 1'b0;

	set_assoc_cache_lru_fifo_tracker_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.address_valid(address_valid),
		.address_stall(address_stall),
		.address(address),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.hit(hit),
		.way(way),
		.miss_count(miss_count),
		.access_count(access_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// way w becomes youngest; valid ways younger than its old rank age by one
	function automatic void promote_way(input int base, input int w);
		int old_rank;
		int i;
		old_rank = line_valid[base + w] ? line_age[base + w] : NWAYS;
		for (i = 0; i < NWAYS; i++) begin
			if (i != w && line_valid[base + i] && line_age[base + i] < old_rank)
				line_age[base + i]++;
		end
		line_age[base + w] = 0;
	endfunction

	function automatic lookup_t cache_lookup(input logic [AW-1:0] addr);
		logic [AW-1:0] blk;
		int base;
		int slot;
		int oldest;
		int w;
		bit found;
		lookup_t res;
		blk = addr >> cur_offset_bits;
		base = (int'(blk & ((32'd1 << cur_set_bits) - 32'd1)) % NSETS) * NWAYS;
		found = 1'b0;
		slot = 0;
		for (w = 0; w < NWAYS; w++) begin
			if (!found && line_valid[base + w] && line_tag[base + w] == blk) begin
				found = 1'b1;
				slot = w;
			end
		end
		if (accesses_seen != '1)
			accesses_seen++;
		if (found) begin
			if (cur_mode == sacache_pkg::MODE_LRU)
				promote_way(base, slot);
		end else begin
			for (w = NWAYS - 1; w >= 0; w--) begin
				if (!line_valid[base + w]) begin
					found = 1'b1;
					slot = w;
				end
			end
			if (!found) begin
				// set full: lowest way among the oldest goes
				oldest = 0;
				for (w = 0; w < NWAYS; w++) begin
					if (w == 0 || line_age[base + w] > oldest) begin
						oldest = line_age[base + w];
						slot = w;
					end
				end
			end
			promote_way(base, slot);
			line_tag[base + slot] = blk;
			line_valid[base + slot] = 1'b1;
			if (misses_seen != '1)
				misses_seen++;
			found = 1'b0;
		end
		res.hit = found;
		res.way = slot[sacache_pkg::WAY_OUT_W-1:0];
		res.miss_total = misses_seen;
		res.access_total = accesses_seen;
		return res;
	endfunction

	task automatic check_field(input string field,
			input logic [sacache_pkg::CNT_W-1:0] want,
			input logic [sacache_pkg::CNT_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, field, want, got);
			mismatch_count++;
		end
	endtask

	// address side: predict on every transfer, then present the next address
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_valid <= 1'b0;
			address <= '0;
			tx_gap <= 0;
		end else begin
			if (address_valid && !address_stall)
				expected_lookups.push_back(cache_lookup(address));
			if (!address_valid || !address_stall) begin
				if (tx_gap != 0) begin
					tx_gap <= tx_gap - 1;
					address_valid <= 1'b0;
				end else if (pending_addrs.size() != 0) begin
					address_valid <= 1'b1;
					address <= pending_addrs.pop_front();
					if (tx_idle_en && $urandom_range(0, 3) == 0)
						tx_gap <= $urandom_range(1, 6);
				end else begin
					address_valid <= 1'b0;
				end
			end
		end
	end

	// result side: compare each transfer with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			rx_hold <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_lookups.size() == 0) begin
					$display("%0t: unexpected result hit %0h way %0h", $time, hit, way);
					mismatch_count++;
				end else begin
					oldest_lookup = expected_lookups.pop_front();
					check_field("hit", sacache_pkg::CNT_W'(oldest_lookup.hit),
						sacache_pkg::CNT_W'(hit));
					check_field("way", sacache_pkg::CNT_W'(oldest_lookup.way),
						sacache_pkg::CNT_W'(way));
					check_field("miss_count", oldest_lookup.miss_total, miss_count);
					check_field("access_count", oldest_lookup.access_total, access_count);
				end
			end
			if (rx_hold != 0) begin
				rx_hold <= rx_hold - 1;
				result_stall <= 1'b1;
			end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
				rx_hold <= $urandom_range(0, 5);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	task automatic queue_access(input logic [AW-1:0] a);
		pending_addrs.push_back(a);
		recent_addrs.push_back(a);
		if (recent_addrs.size() > 64)
			void'(recent_addrs.pop_front());
	endtask

	task automatic wait_drained();
		while (pending_addrs.size() != 0 || address_valid || expected_lookups.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [sacache_pkg::CFG_IDX_W-1:0] idx,
			input logic [sacache_pkg::CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			sacache_pkg::REG_REPLACE_MODE: cur_mode = data[0];
			sacache_pkg::REG_BLOCK_OFFSET: cur_offset_bits = data;
			sacache_pkg::REG_SET_INDEX: cur_set_bits = data;
			default: ;
		endcase
	endtask

	// new settings on an idle block, then a burst of accesses around a few hot sets
	task automatic run_phase(input logic mode, input logic [sacache_pkg::SHIFT_W-1:0] off,
			input logic [sacache_pkg::SHIFT_W-1:0] sib, input int count, input bit idle_en);
		logic [AW-1:0] hot_blocks [12];
		int hot_n;
		int sets_n;
		int pick;
		int i;
		logic [AW-1:0] a;
		wait_drained();
		repeat (4) @(posedge clk);
		write_reg(sacache_pkg::REG_REPLACE_MODE, sacache_pkg::CFG_W'(mode));
		write_reg(sacache_pkg::REG_BLOCK_OFFSET, off);
		write_reg(sacache_pkg::REG_SET_INDEX, sib);
		tx_idle_en <= idle_en;
		rx_idle_en <= idle_en;
		hot_n = $urandom_range(5, 12);
		sets_n = $urandom_range(1, 3);
		if (sets_n > (1 << sib))
			sets_n = 1 << sib;
		for (i = 0; i < hot_n; i++)
			hot_blocks[i] = ($urandom << sib) | AW'($urandom_range(0, sets_n - 1));
		@(negedge clk);
		for (i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				a = (hot_blocks[$urandom_range(0, hot_n - 1)] << off)
					| ($urandom & ((32'd1 << off) - 32'd1));
			else if (pick < 85)
				a = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
			else
				a = $urandom;
			queue_access(a);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		tx_idle_en <= 1'b1;
		rx_idle_en <= 1'b1;
		@(negedge clk);
		// reset settings, lru: address extremes, hits in one block, eviction in set 0
		queue_access(32'h0000_0000);
		queue_access(32'h0000_0000);
		queue_access(32'h0000_000F);
		queue_access(32'hFFFF_FFFF);
		queue_access(32'hFFFF_FFF0);
		queue_access(32'h0000_0100);
		queue_access(32'h0000_0200);
		queue_access(32'h0000_0300);
		queue_access(32'h0000_0005);
		queue_access(32'h0000_0400);
		queue_access(32'h0000_0100);
		wait_drained();
		repeat (4) @(posedge clk);
		// unused register index is dropped, mode data is cut to one bit
		write_reg(REG_NONE, sacache_pkg::CFG_W'(7));
		write_reg(sacache_pkg::REG_REPLACE_MODE, sacache_pkg::CFG_W'(3));
		@(negedge clk);
		// fifo: a hit does not save way 0 from eviction
		queue_access(32'h0000_0010);
		queue_access(32'h0000_0110);
		queue_access(32'h0000_0210);
		queue_access(32'h0000_0310);
		queue_access(32'h0000_0010);
		queue_access(32'h0000_0410);
		queue_access(32'h0000_0010);

		run_phase(sacache_pkg::MODE_LRU, 3'd4, 3'd4, 85, 1'b1);
		run_phase(sacache_pkg::MODE_FIFO, 3'd0, 3'd0, 85, 1'b1);
		run_phase(sacache_pkg::MODE_LRU, 3'd7, 3'd7, 85, 1'b1);
		run_phase(sacache_pkg::MODE_FIFO, 3'd7, 3'd0, 85, 1'b1);
		run_phase(sacache_pkg::MODE_LRU, 3'd0, 3'd7, 85, 1'b1);
		repeat (4)
			run_phase(logic'($urandom_range(0, 1)),
				sacache_pkg::SHIFT_W'($urandom_range(0, 7)),
				sacache_pkg::SHIFT_W'($urandom_range(0, 7)), 85,
				$urandom_range(0, 3) != 0);
		run_phase(logic'($urandom_range(0, 1)), 3'd2, 3'd2, 70, 1'b0);

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#(20 * 200000);
		$display("Mismatches found");
		$finish;
	end

endmodule
